// File: hdl/logic_timer_slot_bank_assert.svh
// ----------------------------------------------------------------------------
// Timer slot bank assertion macros
// Concurrent property wrappers that compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef LOGIC_TIMER_SLOT_BANK_ASSERT_SVH
`define LOGIC_TIMER_SLOT_BANK_ASSERT_SVH

`ifndef SYNTHESIS
`define TSB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TSB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TSB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TSB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hdl/tsb_pkg.sv
// ----------------------------------------------------------------------------
// Timer slot bank package
// Shared widths, command codes and sequencer states.
// ----------------------------------------------------------------------------
package tsb_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int KIND_W    = 2;
	localparam int SLOT_W    = 5;
	localparam int REQ_W     = 32;
	localparam int TICK_W    = 16;
	localparam int PERIOD_W  = 31;
	localparam int ELAPSED_W = 32;
	localparam int FIRED_W   = 4;
	localparam int REC_W     = PERIOD_W + ELAPSED_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK   = 2'd0,
		KIND_ARM    = 2'd1,
		KIND_DISARM = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

endpackage

// File: hdl/tsb_mem.sv
// ----------------------------------------------------------------------------
// Timer slot record memory
// One write port, one read port with a registered read.
// ----------------------------------------------------------------------------
module tsb_mem #(
	parameter int DEPTH = tsb_pkg::SLOTS_DEF,
	parameter int AW    = 4,
	parameter int DW    = tsb_pkg::REC_W
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/tsb_ctrl.sv
// ----------------------------------------------------------------------------
// Timer slot bank controller
// Command decode, armed flags, slot scan sequencer with read-modify-write of
// the slot memory, and the fired-slot result register.
// ----------------------------------------------------------------------------
module tsb_ctrl #(
	parameter int SLOTS = tsb_pkg::SLOTS_DEF,
	parameter int IW    = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tsb_pkg::KIND_W-1:0]        kind,
	input  logic [tsb_pkg::SLOT_W-1:0]        slot,
	input  logic signed [tsb_pkg::REQ_W-1:0]  req_period,
	input  logic [tsb_pkg::TICK_W-1:0]        tick_ms,
	output logic                              busy,
	output logic                              strobe,
	output logic [tsb_pkg::FIRED_W-1:0]       fired_slot,
	output logic                              last,
	output logic                              wr_en,
	output logic [IW-1:0]                     wr_addr,
	output logic [tsb_pkg::REC_W-1:0]         wr_data,
	output logic                              rd_en,
	output logic [IW-1:0]                     rd_addr,
	input  logic [tsb_pkg::REC_W-1:0]         rd_data
);

	localparam int SW = tsb_pkg::SLOT_W;
	localparam int PW = tsb_pkg::PERIOD_W;
	localparam int EW = tsb_pkg::ELAPSED_W;
	localparam int FW = tsb_pkg::FIRED_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
	localparam logic [SW:0]   BANK     = (SW + 1)'(SLOTS);

	tsb_pkg::state_t state_q, state_d;

	logic [IW-1:0]     cnt_q;
	logic [15:0]       tick_q;
	logic [SLOTS-1:0]  armed_q;
	logic              vld_s2;
	logic [IW-1:0]     idx_s2;
	logic              pend_vld_q;
	logic [SW-1:0]     pend_idx_q;
	logic              strobe_q;
	logic [FW-1:0]     fired_q;
	logic              last_q;

	logic              acc;
	logic              slot_ok;
	logic              arm_we;
	logic              disarm_we;
	logic              tick_go;
	logic [IW-1:0]     slot_idx;
	logic              req_pos;
	logic [PW-1:0]     arm_period;
	logic [PW-1:0]     rec_period;
	logic [EW-1:0]     rec_elapsed;
	logic [EW-1:0]     sum;
	logic              hit;
	logic              fire;
	logic              wb_en;
	logic              emit;
	logic              flush_emit;

	assign acc       = start && !busy;
	assign slot_ok   = {1'b0, slot} < BANK;
	assign slot_idx  = slot[IW-1:0];
	assign arm_we    = acc && (kind == tsb_pkg::KIND_ARM) && slot_ok;
	assign disarm_we = acc && (kind == tsb_pkg::KIND_DISARM) && slot_ok;
	assign tick_go   = acc && (kind == tsb_pkg::KIND_TICK);

	assign req_pos    = (req_period != '0) && !req_period[tsb_pkg::REQ_W-1];
	assign arm_period = req_pos ? req_period[PW-1:0] : PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		rd_en   = 1'b0;
		unique case (state_q)
			tsb_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (tick_go) begin
					state_d = tsb_pkg::ST_SCAN;
				end
			end
			tsb_pkg::ST_SCAN: begin
				rd_en = 1'b1;
				if (cnt_q == LAST_IDX) begin
					state_d = tsb_pkg::ST_DRAIN;
				end
			end
			tsb_pkg::ST_DRAIN: begin
				state_d = tsb_pkg::ST_FLUSH;
			end
			tsb_pkg::ST_FLUSH: begin
				state_d = tsb_pkg::ST_IDLE;
			end
			default: begin
				state_d = tsb_pkg::ST_IDLE;
			end
		endcase
	end

	assign rd_addr = cnt_q;

	// slot evaluation on returned record
	assign rec_period  = rd_data[EW +: PW];
	assign rec_elapsed = rd_data[EW-1:0];
	assign sum         = rec_elapsed + EW'(tick_q);
	assign hit         = vld_s2 && armed_q[idx_s2];
	assign fire        = hit && (sum >= {1'b0, rec_period});
	assign wb_en       = hit;

	always_comb begin
		if (arm_we) begin
			wr_en   = 1'b1;
			wr_addr = slot_idx;
			wr_data = {arm_period, EW'(0)};
		end else begin
			wr_en   = wb_en;
			wr_addr = idx_s2;
			wr_data = {rec_period, fire ? EW'(0) : sum};
		end
	end

	assign emit       = fire && pend_vld_q;
	assign flush_emit = (state_q == tsb_pkg::ST_FLUSH) && pend_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q    <= '0;
			vld_s2     <= 1'b0;
			pend_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (arm_we) begin
				armed_q[slot_idx] <= 1'b1;
			end else if (disarm_we) begin
				armed_q[slot_idx] <= 1'b0;
			end
			if (tick_go) begin
				cnt_q <= '0;
			end else if (state_q == tsb_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + IW'(1);
			end
			vld_s2   <= (state_q == tsb_pkg::ST_SCAN);
			strobe_q <= emit || flush_emit;
			if (fire) begin
				pend_vld_q <= 1'b1;
			end else if (state_q == tsb_pkg::ST_FLUSH) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			tick_q <= tick_ms;
		end
		idx_s2 <= cnt_q;
		if (fire) begin
			pend_idx_q <= SW'(idx_s2);
		end
		if (emit || flush_emit) begin
			fired_q <= pend_idx_q[FW-1:0];
			last_q  <= flush_emit;
		end
	end

	assign strobe     = strobe_q;
	assign fired_slot = fired_q;
	assign last       = last_q;

endmodule

// File: hdl/logic_timer_slot_bank.sv
// ----------------------------------------------------------------------------
// Timer slot bank
// A bank of periodic millisecond timer slots driven by tick, arm and disarm
// commands.
// ----------------------------------------------------------------------------
// Arm and disarm commands complete in the cycle they are accepted. A tick
// keeps busy high through its scan, drain and flush states: slot records are
// walked one per cycle through the single read port of the slot memory, with
// a read-modify-write of each record. Each fired slot appears as a one-cycle
// strobe with fired_slot; the final one of the tick carries last. Results are
// reported one slot late, so the first strobe of a tick comes no earlier than
// its second fired slot or the end of the scan. The receiver cannot stall
// results; a transaction on the result ports is complete when strobe is seen.
module logic_timer_slot_bank #(
	parameter int SLOTS = tsb_pkg::SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [tsb_pkg::KIND_W-1:0]        kind,
	input  logic [tsb_pkg::SLOT_W-1:0]        slot,
	input  logic signed [tsb_pkg::REQ_W-1:0]  req_period,
	input  logic [tsb_pkg::TICK_W-1:0]        tick_ms,
	output logic                              strobe,
	output logic [tsb_pkg::FIRED_W-1:0]       fired_slot,
	output logic                              last
);

`include "logic_timer_slot_bank_assert.svh"

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic                      wr_en;
	logic [IW-1:0]             wr_addr;
	logic [tsb_pkg::REC_W-1:0] wr_data;
	logic                      rd_en;
	logic [IW-1:0]             rd_addr;
	logic [tsb_pkg::REC_W-1:0] rd_data;
	logic                      acc_cmd;
	logic                      is_tick;

	assign acc_cmd = start && !busy;
	assign is_tick = (kind == tsb_pkg::KIND_TICK);

	tsb_ctrl #(
		.SLOTS(SLOTS),
		.IW   (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.kind      (kind),
		.slot      (slot),
		.req_period(req_period),
		.tick_ms   (tick_ms),
		.busy      (busy),
		.strobe    (strobe),
		.fired_slot(fired_slot),
		.last      (last),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	tsb_mem #(
		.DEPTH(SLOTS),
		.AW   (IW),
		.DW   (tsb_pkg::REC_W)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	`TSB_ASSERT_NXT(a_tick_busy, clk, arst_n, acc_cmd && is_tick, busy, "tick did not raise busy")
	`TSB_ASSERT_NXT(a_last_gap, clk, arst_n, strobe && last, !strobe, "strobe right after last")
	`TSB_ASSERT_NXT(a_idle_quiet, clk, arst_n, !busy, !(strobe && !last), "early non-final result")
	`TSB_ASSERT_IMP(a_ctl_busy, clk, arst_n, acc_cmd && !is_tick, ##1 !busy, "arm or disarm held busy")

endmodule

// File: dv/logic_timer_slot_bank_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer slot bank testbench
// Drives tick, arm and disarm commands through the start/busy handshake and
// checks every fired-slot strobe against a cycle-free model of the slot bank:
// armed marks, periods and elapsed times advanced per accepted transaction.
// A directed opening covers period clamping, out-of-bank slots, the unused
// kind and a tick that fires every slot; random commands with idle bursts
// follow.
// ----------------------------------------------------------------------------
module logic_timer_slot_bank_tb;

	localparam int KIND_W    = tsb_pkg::KIND_W;
	localparam int SLOT_W    = tsb_pkg::SLOT_W;
	localparam int REQ_W     = tsb_pkg::REQ_W;
	localparam int TICK_W    = tsb_pkg::TICK_W;
	localparam int PERIOD_W  = tsb_pkg::PERIOD_W;
	localparam int ELAPSED_W = tsb_pkg::ELAPSED_W;
	localparam int FIRED_W   = tsb_pkg::FIRED_W;

	localparam int N_SLOTS = tsb_pkg::SLOTS_DEF;
	localparam int RANDOM_ITEMS = 443;
	localparam int CALM_TAIL = 50;
	localparam int STALL_LIMIT = 2000;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [REQ_W-1:0]  req_period;
		logic [TICK_W-1:0] tick_ms;
	} cmd_t;

	typedef struct {
		logic [FIRED_W-1:0] slot;
		logic               last;
	} fire_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [KIND_W-1:0]        kind = '0;
	logic [SLOT_W-1:0]        slot = '0;
	logic signed [REQ_W-1:0]  req_period = '0;
	logic [TICK_W-1:0]        tick_ms = '0;
	logic                     strobe;
	logic [FIRED_W-1:0]       fired_slot;
	logic                     last;

	cmd_t  pending[$];
	fire_t fires_due[$];
	cmd_t  cur;
	int    n_total = -1;
	int    n_accepted = 0;
	int    gap_left = 0;
	int    idle_pct = 10;
	int    errors = 0;
	int    stall_cycles = 0;

	logic                 armed_q   [N_SLOTS];
	logic [PERIOD_W-1:0]  period_q  [N_SLOTS];
	logic [ELAPSED_W-1:0] elapsed_q [N_SLOTS];

	logic_timer_slot_bank #(.SLOTS(N_SLOTS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.slot       (slot),
		.req_period (req_period),
		.tick_ms    (tick_ms),
		.strobe     (strobe),
		.fired_slot (fired_slot),
		.last       (last)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		errors++;
	endtask

	// advance the slot bank by one command and queue the slots it fires
	task automatic apply_command(input cmd_t c);
		fire_t f;
		int    n;
		n = 0;
		if (c.kind == tsb_pkg::KIND_ARM) begin
			if (c.slot < N_SLOTS) begin
				armed_q[c.slot] = 1'b1;
				period_q[c.slot] = (c.req_period != '0 && !c.req_period[REQ_W-1]) ?
					c.req_period[PERIOD_W-1:0] : PERIOD_W'(1);
				elapsed_q[c.slot] = '0;
			end
		end else if (c.kind == tsb_pkg::KIND_DISARM) begin
			if (c.slot < N_SLOTS)
				armed_q[c.slot] = 1'b0;
		end else if (c.kind == tsb_pkg::KIND_TICK) begin
			for (int s = 0; s < N_SLOTS; s++) begin
				if (armed_q[s]) begin
					elapsed_q[s] = elapsed_q[s] + ELAPSED_W'(c.tick_ms);
					if (elapsed_q[s] >= {1'b0, period_q[s]}) begin
						elapsed_q[s] = '0;
						f.slot = FIRED_W'(s);
						f.last = 1'b0;
						fires_due.push_back(f);
						n++;
					end
				end
			end
			if (n > 0)
				fires_due[fires_due.size() - 1].last = 1'b1;
		end
	endtask

	function automatic cmd_t make_cmd(input logic [KIND_W-1:0] k, input int s,
			input logic [REQ_W-1:0] p, input logic [TICK_W-1:0] t);
		cmd_t c;
		c.kind = k;
		c.slot = SLOT_W'(s);
		c.req_period = p;
		c.tick_ms = t;
		return c;
	endfunction

	function automatic int random_slot();
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(0, N_SLOTS - 1);
		return $urandom_range(N_SLOTS, 31);
	endfunction

	function automatic cmd_t random_command();
		cmd_t c;
		int   pick;
		c = make_cmd(KIND_UNUSED, $urandom_range(0, 31), $urandom, TICK_W'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			c.kind = tsb_pkg::KIND_TICK;
			case ($urandom_range(0, 9))
				8:       c.tick_ms = '0;
				9:       c.tick_ms = TICK_W'($urandom);
				default: c.tick_ms = TICK_W'($urandom_range(0, 120));
			endcase
		end else if (pick < 75) begin
			c.kind = tsb_pkg::KIND_ARM;
			c.slot = SLOT_W'(random_slot());
			case ($urandom_range(0, 9))
				7:       c.req_period = '0;
				8:       c.req_period = $urandom | 32'h8000_0000;
				9:       c.req_period = $urandom;
				default: c.req_period = $urandom_range(1, 400);
			endcase
		end else if (pick < 96) begin
			c.kind = tsb_pkg::KIND_DISARM;
			c.slot = SLOT_W'(random_slot());
		end
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				apply_command(cur);
				n_accepted++;
				if (n_accepted % 50 == 0)
					case ($urandom_range(0, 2))
						0:       idle_pct = 0;
						1:       idle_pct = 10;
						default: idle_pct = 35;
					endcase
			end
			if (!start || !busy) begin
				if (gap_left == 0 && pending.size() > CALM_TAIL &&
						$urandom_range(0, 99) < idle_pct)
					gap_left = $urandom_range(1, 7);
				if (gap_left > 0) begin
					start <= 1'b0;
					gap_left--;
				end else if (pending.size() > 0) begin
					cur = pending.pop_front();
					start <= 1'b1;
					kind <= cur.kind;
					slot <= cur.slot;
					req_period <= cur.req_period;
					tick_ms <= cur.tick_ms;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		fire_t e;
		if (arst_n) begin
			if (strobe) begin
				if (fires_due.size() == 0) begin
					report_mismatch($sformatf("unexpected strobe, slot %0d last %0b",
						fired_slot, last));
				end else begin
					e = fires_due.pop_front();
					if (fired_slot !== e.slot)
						report_mismatch($sformatf("fired_slot %0d, want %0d",
							fired_slot, e.slot));
					if (last !== e.last)
						report_mismatch($sformatf("last %0b on slot %0d, want %0b",
							last, e.slot, e.last));
				end
			end
			if ((start && !busy) || strobe)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		for (int s = 0; s < N_SLOTS; s++)
			armed_q[s] = 1'b0;

		pending.push_back(make_cmd(tsb_pkg::KIND_TICK, 9, 32'h1234_5678, 16'd0));
		pending.push_back(make_cmd(tsb_pkg::KIND_ARM, 0, 32'h0000_0000, 16'hFFFF));
		pending.push_back(make_cmd(tsb_pkg::KIND_ARM, 15, 32'hFFFF_FFFF, 16'h0000));
		pending.push_back(make_cmd(tsb_pkg::KIND_ARM, 7, 32'h8000_0000, 16'hA5A5));
		pending.push_back(make_cmd(tsb_pkg::KIND_ARM, 3, 32'h7FFF_FFFF, 16'h5A5A));
		pending.push_back(make_cmd(tsb_pkg::KIND_ARM, 16, 32'd5, 16'd0));
		pending.push_back(make_cmd(tsb_pkg::KIND_DISARM, 31, 32'hFFFF_FFFF, 16'hFFFF));
		pending.push_back(make_cmd(KIND_UNUSED, 1, 32'd1, 16'd1));
		pending.push_back(make_cmd(tsb_pkg::KIND_TICK, 31, 32'hFFFF_FFFF, 16'd0));
		pending.push_back(make_cmd(tsb_pkg::KIND_TICK, 0, 32'd0, 16'hFFFF));
		pending.push_back(make_cmd(tsb_pkg::KIND_DISARM, 7, 32'd0, 16'd0));
		pending.push_back(make_cmd(tsb_pkg::KIND_TICK, 5, 32'd9, 16'd1));
		for (int s = 1; s < N_SLOTS - 1; s++)
			pending.push_back(make_cmd(tsb_pkg::KIND_ARM, s, 32'd1, 16'd0));
		pending.push_back(make_cmd(tsb_pkg::KIND_TICK, 0, 32'd0, 16'd1));

		for (int i = 0; i < RANDOM_ITEMS; i++)
			pending.push_back(random_command());
		n_total = pending.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (n_accepted == n_total);
		while (fires_due.size() != 0)
			@(posedge clk);
		repeat (4 * N_SLOTS) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
